@@ hdl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

	typedef enum logic [3:0] {
		PH_DELTA  = 4'd0,
		PH_STATUS = 4'd1,
		PH_DATA1  = 4'd2,
		PH_DATA2  = 4'd3,
		PH_MTYPE  = 4'd4,
		PH_MLEN1  = 4'd5,
		PH_MLEN   = 4'd6,
		PH_MSKIP  = 4'd7,
		PH_TEMPO  = 4'd8,
		PH_XLEN   = 4'd9,
		PH_XDATA  = 4'd10
	} phase_t;

	localparam logic [2:0] KIND_CHANNEL = 3'd0;
	localparam logic [2:0] KIND_TEMPO   = 3'd1;
	localparam logic [2:0] KIND_SYSEX   = 3'd2;
	localparam logic [2:0] KIND_EOT     = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [7:0] DATA_MASK    = 8'h7F;
	localparam logic [7:0] STATUS_BIT   = 8'h80;
	localparam logic [7:0] META_STATUS  = 8'hFF;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
	localparam logic [7:0] TEMPO_LEN    = 8'h03;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] delta;
		logic [7:0]  status;
		logic [7:0]  lead_data;
		logic [7:0]  second_data;
		logic [23:0] tempo;
		logic        sysex_end;
	} result_t;

endpackage

@@ hdl/mtep_in_reg.sv @@
// ----------------------------------------------------------------------------
// mtep_in_reg
// Input register: captures one body byte per beat ahead of the decoder.
// ----------------------------------------------------------------------------
module mtep_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  mtep_pkg::beat_t beat,
	input  logic            advance,
	output logic            valid_s1,
	output mtep_pkg::beat_t beat_s1
);
	import mtep_pkg::*;

	logic valid_q;

	assign item_ready = !valid_q || advance;
	assign valid_s1   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			beat_s1 <= beat;
		end
	end

endmodule

@@ hdl/mtep_core.sv @@
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and one-byte decode: delta times, running status, meta and
// sysex handling, truncation.
// ----------------------------------------------------------------------------
module mtep_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mtep_pkg::beat_t   beat_s1,
	output logic              emit,
	output mtep_pkg::result_t result
);
	import mtep_pkg::*;

	phase_t      phase_q, phase_n;
	logic [7:0]  rs_q, rs_n;
	logic [31:0] dacc_q, dacc_n;
	logic [31:0] carry_q, carry_n;
	logic [7:0]  held_q, held_n;
	logic [7:0]  mtype_q, mtype_n;
	logic [31:0] rem_q, rem_n;
	logic [23:0] tacc_q, tacc_n;
	logic        ended_q, ended_n;

	logic [7:0]  b;
	logic        last;
	logic        done;
	logic [31:0] len_base;

	assign b    = beat_s1.data_byte;
	assign last = beat_s1.last_byte;

	always_comb begin
		phase_n  = phase_q;
		rs_n     = rs_q;
		dacc_n   = dacc_q;
		carry_n  = carry_q;
		held_n   = held_q;
		mtype_n  = mtype_q;
		rem_n    = rem_q;
		tacc_n   = tacc_q;
		ended_n  = ended_q;
		done     = 1'b0;
		emit     = 1'b0;
		result   = '0;
		len_base = '0;

		if (!ended_q) begin
			case (phase_q)
				PH_DELTA: begin
					dacc_n = {dacc_q[24:0], b[6:0]};
					if ((b & STATUS_BIT) == 8'h00) begin
						phase_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if ((b & STATUS_BIT) != 8'h00) begin
						rs_n = b;
						if (b < SYSEX_START) begin
							phase_n = PH_DATA1;
						end else if (b == META_STATUS) begin
							phase_n = PH_MTYPE;
						end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
							rem_n   = '0;
							phase_n = PH_XLEN;
						end else begin
							emit        = 1'b1;
							result.kind = KIND_ERROR;
							ended_n     = 1'b1;
							done        = 1'b1;
						end
					end else if (rs_q inside {[8'h80:8'hEF]}) begin
						// data under running status
						if (rs_q[7:4] != 4'hC && rs_q[7:4] != 4'hD) begin
							held_n  = b;
							phase_n = PH_DATA2;
						end else begin
							emit             = 1'b1;
							result.kind      = KIND_CHANNEL;
							result.lead_data = b;
							phase_n          = PH_DELTA;
							done             = 1'b1;
						end
					end else begin
						emit        = 1'b1;
						result.kind = KIND_ERROR;
						ended_n     = 1'b1;
						done        = 1'b1;
					end
				end
				PH_DATA1: begin
					if (rs_q[7:4] != 4'hC && rs_q[7:4] != 4'hD) begin
						held_n  = b;
						phase_n = PH_DATA2;
					end else begin
						emit             = 1'b1;
						result.kind      = KIND_CHANNEL;
						result.lead_data = b;
						phase_n          = PH_DELTA;
						done             = 1'b1;
					end
				end
				PH_DATA2: begin
					emit               = 1'b1;
					result.kind        = KIND_CHANNEL;
					result.lead_data   = held_q;
					result.second_data = b;
					phase_n            = PH_DELTA;
					done               = 1'b1;
				end
				PH_MTYPE: begin
					if (b == META_EOT) begin
						emit        = 1'b1;
						result.kind = KIND_EOT;
						ended_n     = 1'b1;
						done        = 1'b1;
					end else begin
						mtype_n = b;
						phase_n = PH_MLEN1;
					end
				end
				PH_MLEN1, PH_MLEN: begin
					if (phase_q == PH_MLEN1 && mtype_q == META_TEMPO && b == TEMPO_LEN) begin
						rem_n   = 32'd3;
						tacc_n  = '0;
						phase_n = PH_TEMPO;
					end else begin
						len_base = (phase_q == PH_MLEN1) ? 32'd0 : rem_q;
						rem_n    = {len_base[24:0], b[6:0]};
						if ((b & STATUS_BIT) != 8'h00) begin
							phase_n = PH_MLEN;
						end else if (rem_n == 32'd0) begin
							// empty meta: fold its delta into the next event
							carry_n = carry_q + dacc_q;
							dacc_n  = '0;
							phase_n = PH_DELTA;
							done    = 1'b1;
						end else begin
							phase_n = PH_MSKIP;
						end
					end
				end
				PH_MSKIP: begin
					rem_n = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						carry_n = carry_q + dacc_q;
						dacc_n  = '0;
						phase_n = PH_DELTA;
						done    = 1'b1;
					end
				end
				PH_TEMPO: begin
					tacc_n = {tacc_q[15:0], b};
					rem_n  = rem_q - 32'd1;
					if (rem_n == 32'd0) begin
						emit         = 1'b1;
						result.kind  = KIND_TEMPO;
						result.tempo = tacc_n;
						phase_n      = PH_DELTA;
						done         = 1'b1;
					end
				end
				PH_XLEN: begin
					rem_n = {rem_q[24:0], b[6:0]};
					if ((b & STATUS_BIT) == 8'h00) begin
						if (rem_n == 32'd0) begin
							carry_n = carry_q + dacc_q;
							dacc_n  = '0;
							phase_n = PH_DELTA;
							done    = 1'b1;
						end else begin
							phase_n = PH_XDATA;
						end
					end
				end
				PH_XDATA: begin
					rem_n            = rem_q - 32'd1;
					emit             = 1'b1;
					result.kind      = KIND_SYSEX;
					result.lead_data = b;
					result.sysex_end = (rem_n == 32'd0);
					if (rem_n == 32'd0) begin
						phase_n = PH_DELTA;
						done    = 1'b1;
					end
				end
				default: begin
					phase_n = PH_DELTA;
				end
			endcase
		end

		// delta and status as seen at the emit; a fired emit clears the sums
		if (emit) begin
			result.delta  = carry_n + dacc_n;
			result.status = rs_n;
			carry_n       = '0;
			dacc_n        = '0;
		end

		if (last) begin
			// truncated track: unless this byte completed an event, replace its output with an error
			if (!ended_q && !done) begin
				result        = '0;
				result.kind   = KIND_ERROR;
				result.delta  = carry_n + dacc_n;
				result.status = rs_n;
				emit          = 1'b1;
			end
			phase_n = PH_DELTA;
			rs_n    = '0;
			dacc_n  = '0;
			carry_n = '0;
			held_n  = '0;
			mtype_n = '0;
			rem_n   = '0;
			tacc_n  = '0;
			ended_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			rs_q    <= '0;
			dacc_q  <= '0;
			carry_q <= '0;
			held_q  <= '0;
			mtype_q <= '0;
			rem_q   <= '0;
			tacc_q  <= '0;
			ended_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			rs_q    <= rs_n;
			dacc_q  <= dacc_n;
			carry_q <= carry_n;
			held_q  <= held_n;
			mtype_q <= mtype_n;
			rem_q   <= rem_n;
			tacc_q  <= tacc_n;
			ended_q <= ended_n;
		end
	end

endmodule

@@ hdl/mtep_out_reg.sv @@
// ----------------------------------------------------------------------------
// mtep_out_reg
// Result register: holds one decoded event until the consumer takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic              emit,
	input  mtep_pkg::result_t result,
	input  logic              result_ready,
	output logic              advance,
	output logic              result_valid,
	output mtep_pkg::result_t result_s2
);
	import mtep_pkg::*;

	logic valid_q;

	// move the stage-1 beat whenever the result slot is free or draining
	assign advance      = valid_s1 && (!valid_q || result_ready);
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_s2 <= result;
		end
	end

endmodule

@@ hdl/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Standard MIDI file track event parser, one track body byte per beat.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while results are taken, and produces at most one
// event per byte. A byte passes an input register, is decoded combinationally
// against the parser state, and lands in a result register, from which its
// event is offered; while the result register is full and not read, the byte
// waits in the input register. The result register frees as it is read, so a
// new byte is taken in the same cycle that a waiting event leaves.
module midi_track_event_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  kind,
	output logic [31:0] delta,
	output logic [7:0]  status,
	output logic [7:0]  lead_data,
	output logic [7:0]  second_data,
	output logic [23:0] tempo,
	output logic        sysex_end
);
	import mtep_pkg::*;

	beat_t   beat;
	beat_t   beat_s1;
	logic    valid_s1;
	logic    advance;
	logic    emit;
	result_t result;
	result_t result_s2;

	assign beat.data_byte = data_byte;
	assign beat.last_byte = last_byte;

	mtep_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.beat       (beat),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	mtep_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.beat_s1 (beat_s1),
		.emit    (emit),
		.result  (result)
	);

	mtep_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.emit         (emit),
		.result       (result),
		.result_ready (result_ready),
		.advance      (advance),
		.result_valid (result_valid),
		.result_s2    (result_s2)
	);

	assign kind        = result_s2.kind;
	assign delta       = result_s2.delta;
	assign status      = result_s2.status;
	assign lead_data   = result_s2.lead_data;
	assign second_data = result_s2.second_data;
	assign tempo       = result_s2.tempo;
	assign sysex_end   = result_s2.sysex_end;

endmodule

@@ hdl/mtep_checker.sv @@
// ----------------------------------------------------------------------------
// mtep_checker
// Port-level checks on the result channel of the track event parser.
// ----------------------------------------------------------------------------
module mtep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  kind,
	input logic [7:0]  status,
	input logic [7:0]  lead_data,
	input logic [23:0] tempo,
	input logic        sysex_end
);
	import mtep_pkg::*;

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(tempo)
		&& $stable(lead_data))
		else $error("result changed while stalled");

	a_sysex_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sysex_end |-> kind == KIND_SYSEX)
		else $error("sysex end flag outside sysex");

	a_meta_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_TEMPO || kind == KIND_EOT) |-> status == META_STATUS)
		else $error("meta result without FF status");

	a_sysex_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_SYSEX |-> status == SYSEX_START || status == SYSEX_ESCAPE)
		else $error("sysex result with wrong status");

	a_tempo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != KIND_TEMPO |-> tempo == 24'd0)
		else $error("tempo set on non-tempo result");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.status       (status),
	.lead_data    (lead_data),
	.tempo        (tempo),
	.sysex_end    (sysex_end)
);
